[hw/rtl/tbs_pkg.sv]
// Shared constants and types for the bilinear texture sampler.
package tbs_pkg;

    localparam int TEXEL_ADDR_BITS = 12;
    localparam int TEXEL_DEPTH     = 1 << TEXEL_ADDR_BITS;

    localparam int COORD_W  = 16;
    localparam int LOG2_W   = 4;
    localparam int POS_W    = 15;                 // integer texel position, below 2^15
    localparam int SCALED_W = COORD_W + POS_W;    // u << log2 holds here
    localparam int FRAC_W   = 16;
    localparam int WF_W     = FRAC_W + 1;         // 65536 - f
    localparam int WGT_W    = 2 * WF_W - 1;       // weights reach 2^32
    localparam int CHAN_W   = 8;
    localparam int PROD_W   = CHAN_W + WGT_W;     // channel times weight
    localparam int SUM_W    = PROD_W + 2;         // four products
    localparam int OUT_W    = 16;
    localparam int OUT_SHIFT = 24;

    localparam logic [1:0] CFG_WIDTH_LOG2  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT_LOG2 = 2'd1;
    localparam logic [1:0] CFG_BILINEAR    = 2'd2;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef struct packed {
        logic valid;
        logic sample;
        logic bilinear;
    } stage_ctl_t;

endpackage

[hw/rtl/texture_bilinear_sampler.sv]
// Bilinear texture sampler top level: handshake, configuration and pipeline.
//
// Samples a power-of-two RGBA texture with wrapping coordinates. One item is
// taken every cycle while in_stall is low; a sample's transfer edge fills the
// input register, and its result then passes through texel read, weights,
// products, and sum into the output register. Loads travel
// down the same pipeline and write the texel store
// at the read stage, so a sample that follows a load sees the new texel.
// Loads give no result. The texel store is two copies of a
// 2^TEXEL_ADDR_BITS x 32 RAM, each with two read ports, which supplies the
// four neighbours together. The store is not cleared at reset: only
// sample texels that have been loaded. The whole pipeline holds while a
// finished result is stalled at the output, so in_stall follows the output
// register's valid and out_stall. Configuration writes are always taken
// (cfg_ready is high) and must only be made while the pipeline is empty.
module texture_bilinear_sampler (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data,
    // input item channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [11:0] texel_address,
    input  logic [31:0] texel_data,
    input  logic [15:0] u_coord,
    input  logic [15:0] v_coord,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] red,
    output logic [15:0] green,
    output logic [15:0] blue,
    output logic [15:0] alpha
);

    logic [tbs_pkg::LOG2_W-1:0] width_log2_reg;
    logic [tbs_pkg::LOG2_W-1:0] height_log2_reg;
    logic                       bilinear_reg;
    logic                       adv;

    tbs_pkg::stage_ctl_t        s1_ctl;
    logic [tbs_pkg::FRAC_W-1:0] s1_fx;
    logic [tbs_pkg::FRAC_W-1:0] s1_fy;
    logic [31:0]                t00;
    logic [31:0]                t10;
    logic [31:0]                t01;
    logic [31:0]                t11;

    // register file; index 3 is unused and ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_log2_reg  <= 4'd6;
            height_log2_reg <= 4'd6;
            bilinear_reg    <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tbs_pkg::CFG_WIDTH_LOG2:  width_log2_reg  <= cfg_data;
                tbs_pkg::CFG_HEIGHT_LOG2: height_log2_reg <= cfg_data;
                tbs_pkg::CFG_BILINEAR:    bilinear_reg    <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // every stage moves unless a result waits at the output
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    tbs_fetch u_fetch (
        .clk             (clk),
        .rst_n           (rst_n),
        .adv             (adv),
        .in_valid        (in_valid),
        .mode            (mode),
        .texel_address   (texel_address),
        .texel_data      (texel_data),
        .u_coord         (u_coord),
        .v_coord         (v_coord),
        .width_log2      (width_log2_reg),
        .height_log2     (height_log2_reg),
        .bilinear_enable (bilinear_reg),
        .s1_ctl          (s1_ctl),
        .s1_fx           (s1_fx),
        .s1_fy           (s1_fy),
        .t00             (t00),
        .t10             (t10),
        .t01             (t01),
        .t11             (t11)
    );

    tbs_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .s1_ctl    (s1_ctl),
        .s1_fx     (s1_fx),
        .s1_fy     (s1_fy),
        .t00       (t00),
        .t10       (t10),
        .t01       (t01),
        .t11       (t11),
        .out_valid (out_valid),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .alpha     (alpha)
    );

endmodule

[hw/rtl/tbs_ram.sv]
// Generic RAM: one write port, two read ports with registered read data.
module tbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

[hw/rtl/tbs_fetch.sv]
// Input stage, wrapped texel addressing and the duplicated texel store.
module tbs_fetch (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic                        mode,
    input  logic [11:0]                 texel_address,
    input  logic [31:0]                 texel_data,
    input  logic [15:0]                 u_coord,
    input  logic [15:0]                 v_coord,
    input  logic [tbs_pkg::LOG2_W-1:0]  width_log2,
    input  logic [tbs_pkg::LOG2_W-1:0]  height_log2,
    input  logic                        bilinear_enable,
    output tbs_pkg::stage_ctl_t         s1_ctl,
    output logic [tbs_pkg::FRAC_W-1:0]  s1_fx,
    output logic [tbs_pkg::FRAC_W-1:0]  s1_fy,
    output logic [31:0]                 t00,
    output logic [31:0]                 t10,
    output logic [31:0]                 t01,
    output logic [31:0]                 t11
);

    localparam int AW = tbs_pkg::TEXEL_ADDR_BITS;
    localparam int PW = tbs_pkg::POS_W;
    localparam int SW = tbs_pkg::SCALED_W;
    localparam int FW = tbs_pkg::FRAC_W;

    logic                 s0_valid_reg;
    logic                 s0_mode_reg;
    logic [11:0]          s0_addr_reg;
    logic [31:0]          s0_data_reg;
    logic [15:0]          s0_u_reg;
    logic [15:0]          s0_v_reg;

    tbs_pkg::stage_ctl_t  s1_ctl_reg;
    logic [FW-1:0]        s1_fx_reg;
    logic [FW-1:0]        s1_fy_reg;

    logic [SW-1:0]        su;
    logic [SW-1:0]        sv;
    logic [PW-1:0]        wmask;
    logic [PW-1:0]        hmask;
    logic [PW-1:0]        x0;
    logic [PW-1:0]        y0;
    logic [PW-1:0]        x1;
    logic [PW-1:0]        y1;
    logic [2*PW-1:0]      row0;
    logic [2*PW-1:0]      row1;
    logic [AW-1:0]        a00;
    logic [AW-1:0]        a10;
    logic [AW-1:0]        a01;
    logic [AW-1:0]        a11;
    logic [AW-1:0]        waddr;
    logic                 we;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_ctl_reg   <= '0;
        end
        else if (adv)
        begin
            s0_valid_reg        <= in_valid;
            s1_ctl_reg.valid    <= s0_valid_reg;
            s1_ctl_reg.sample   <= s0_mode_reg == tbs_pkg::MODE_SAMPLE;
            s1_ctl_reg.bilinear <= bilinear_enable;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_mode_reg <= mode;
            s0_addr_reg <= texel_address;
            s0_data_reg <= texel_data;
            s0_u_reg    <= u_coord;
            s0_v_reg    <= v_coord;
            // nearest mode: zero fractions put the whole weight on t00
            s1_fx_reg   <= bilinear_enable ? su[FW-1:0] : '0;
            s1_fy_reg   <= bilinear_enable ? sv[FW-1:0] : '0;
        end
    end

    always_comb
    begin
        su    = SW'(s0_u_reg) << width_log2;
        sv    = SW'(s0_v_reg) << height_log2;
        wmask = (PW'(1) << width_log2) - PW'(1);
        hmask = (PW'(1) << height_log2) - PW'(1);
        x0    = su[SW-1:FW] & wmask;
        y0    = sv[SW-1:FW] & hmask;
        x1    = (x0 + PW'(1)) & wmask;
        y1    = (y0 + PW'(1)) & hmask;
        row0  = (2*PW)'(y0) << width_log2;
        row1  = (2*PW)'(y1) << width_log2;
        a00   = AW'(row0 | (2*PW)'(x0));
        a10   = AW'(row0 | (2*PW)'(x1));
        a01   = AW'(row1 | (2*PW)'(x0));
        a11   = AW'(row1 | (2*PW)'(x1));
    end

    assign waddr = AW'(s0_addr_reg);
    assign we    = adv && s0_valid_reg && (s0_mode_reg == tbs_pkg::MODE_LOAD);

    // two copies, both written on every load, give four reads a cycle while adv is high
    tbs_ram #(
        .WIDTH (32),
        .DEPTH (tbs_pkg::TEXEL_DEPTH)
    ) u_ram_row0 (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (s0_data_reg),
        .re      (adv),
        .raddr_a (a00),
        .raddr_b (a10),
        .rdata_a (t00),
        .rdata_b (t10)
    );

    tbs_ram #(
        .WIDTH (32),
        .DEPTH (tbs_pkg::TEXEL_DEPTH)
    ) u_ram_row1 (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (s0_data_reg),
        .re      (adv),
        .raddr_a (a01),
        .raddr_b (a11),
        .rdata_a (t01),
        .rdata_b (t11)
    );

    assign s1_ctl = s1_ctl_reg;
    assign s1_fx  = s1_fx_reg;
    assign s1_fy  = s1_fy_reg;

endmodule

[hw/rtl/tbs_blend.sv]
// Weight, product and sum stages of the bilinear blend, plus the output register.
module tbs_blend (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  tbs_pkg::stage_ctl_t         s1_ctl,
    input  logic [tbs_pkg::FRAC_W-1:0]  s1_fx,
    input  logic [tbs_pkg::FRAC_W-1:0]  s1_fy,
    input  logic [31:0]                 t00,
    input  logic [31:0]                 t10,
    input  logic [31:0]                 t01,
    input  logic [31:0]                 t11,
    output logic                        out_valid,
    output logic [15:0]                 red,
    output logic [15:0]                 green,
    output logic [15:0]                 blue,
    output logic [15:0]                 alpha
);

    localparam int WF = tbs_pkg::WF_W;
    localparam int WW = tbs_pkg::WGT_W;
    localparam int PW = tbs_pkg::PROD_W;
    localparam int SM = tbs_pkg::SUM_W;
    localparam int CW = tbs_pkg::CHAN_W;
    localparam int OW = tbs_pkg::OUT_W;

    // corner order: 00, 10, 01, 11
    tbs_pkg::stage_ctl_t  s2_ctl_reg;
    logic [WW-1:0]        w_reg [4];
    logic [31:0]          tex_reg [4];
    tbs_pkg::stage_ctl_t  s3_ctl_reg;
    logic [PW-1:0]        prod_reg [4][4];
    logic                 out_valid_reg;
    logic [OW-1:0]        chan_reg [4];

    logic [WF-1:0]        ifx;
    logic [WF-1:0]        ify;
    logic [WF-1:0]        fx;
    logic [WF-1:0]        fy;
    logic [SM-1:0]        sum [4];

    always_comb
    begin
        fx  = WF'(s1_fx);
        fy  = WF'(s1_fy);
        ifx = (WF'(1) << tbs_pkg::FRAC_W) - fx;
        ify = (WF'(1) << tbs_pkg::FRAC_W) - fy;
    end

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            sum[c] = SM'(prod_reg[0][c]) + SM'(prod_reg[1][c])
                   + SM'(prod_reg[2][c]) + SM'(prod_reg[3][c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_ctl_reg    <= '0;
            s3_ctl_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_ctl_reg    <= s1_ctl;
            s3_ctl_reg    <= s2_ctl_reg;
            out_valid_reg <= s3_ctl_reg.valid && s3_ctl_reg.sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_reg[0]   <= WW'(ifx * ify);
            w_reg[1]   <= WW'(fx * ify);
            w_reg[2]   <= WW'(ifx * fy);
            w_reg[3]   <= WW'(fx * fy);
            // nearest mode does not use the neighbours: keep them out of the sum
            tex_reg[0] <= t00;
            tex_reg[1] <= s1_ctl.bilinear ? t10 : '0;
            tex_reg[2] <= s1_ctl.bilinear ? t01 : '0;
            tex_reg[3] <= s1_ctl.bilinear ? t11 : '0;
            for (int t = 0; t < 4; t++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    prod_reg[t][c] <= PW'(tex_reg[t][c*CW +: CW]) * PW'(w_reg[t]);
                end
            end
            for (int c = 0; c < 4; c++)
            begin
                chan_reg[c] <= sum[c][tbs_pkg::OUT_SHIFT +: OW];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = chan_reg[0];
    assign green     = chan_reg[1];
    assign blue      = chan_reg[2];
    assign alpha     = chan_reg[3];

endmodule
